// ===== hw/rtl/rlft_pkg.sv =====
// Shared types and constants for the LED feedback table with token-bucket limiter.
`default_nettype none
package rlft_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int MAX_RESULTS       = 32;
  localparam int RESULT_CNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int TOKEN_W           = 20;
  localparam int TIME_W            = 32;
  localparam int RATE_W            = 10;
  localparam int DCHAN_W           = 5;
  localparam int CFG_DATA_W        = 10;
  localparam int PROD_W            = TIME_W + RATE_W;
  localparam int SUM_W             = PROD_W + 1;

  localparam logic [RATE_W-1:0]  MAX_RATE_RESET = 10'd100;
  localparam logic [DCHAN_W-1:0] DCHAN_RESET    = 5'd0;
  localparam logic [TOKEN_W-1:0] MILLI_PER_MSG  = 20'd1000;
  localparam logic [4:0]         CHAN_AGNOSTIC  = 5'd16;
  localparam logic [7:0]         STATUS_NOTE    = 8'h90;
  localparam logic [7:0]         STATUS_CC      = 8'hB0;
  localparam logic [3:0]         NIBBLE_MASK    = 4'hF;

  // Configuration register indexes
  localparam logic REG_MAX_RATE     = 1'b0;
  localparam logic REG_DEFAULT_CHAN = 1'b1;

  typedef struct packed {
    logic [6:0] addr;
    logic [4:0] key_chan;
    logic       cc;
    logic [4:0] send_chan;
    logic       want_valid;
    logic [6:0] want_val;
    logic       sent_valid;
    logic [6:0] sent_val;
  } entry_t;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] addr;
    logic [6:0] value;
  } msg_t;

  typedef struct packed {
    logic capture;
    logic scan_start;
    logic adv;
    logic walk;
    logic set_upd;
    logic set_app;
    logic pump_mul;
    logic pump_add;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic q_match;
    logic q_emit;
    logic scan_done;
    logic pend_valid;
    logic out_free;
    logic table_full;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rate_limited_led_feedback_table_unit.sv =====
// LED feedback table with token-bucket rate limiter: sequencer plus datapath.
//
// Input channel (in_valid/in_ready) takes one item at a time. operation 0 is a
// set: the table is searched one entry per cycle through a registered memory
// read, and the entry is updated or appended; a set with led_known low ends as
// it is accepted. operation 1 is a pump: bucket arithmetic (multiply, then add
// and saturate), then a walk of one entry per cycle while the receiver keeps
// up, then a flush step that releases the final message. The length of a set
// or a pump grows with the entries in the table, which holds 32 by default.
// Output channel (out_valid/out_ready) carries one MIDI message per transfer;
// last marks the final message of a pump. A pump that sends nothing produces
// no transfer. One message is held back in a staging register and one sits in
// the output register; when the receiver stalls the walk holds in place.
// The next item is accepted while the last message still waits to be taken.
// Reset (rst, synchronous) empties the table and the bucket, and restores
// max_rate to 100 and default_channel to 0. Configuration writes through
// cfg_we/cfg_index/cfg_data take effect at once and belong to idle periods.
`default_nettype none
module rate_limited_led_feedback_table_unit
  import rlft_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  operation,
  input  wire logic [6:0]            led_addr,
  input  wire logic [4:0]            channel,
  input  wire logic                  led_known,
  input  wire logic                  is_cc,
  input  wire logic                  range_channel_significant,
  input  wire logic [6:0]            colour_value,
  input  wire logic [TIME_W-1:0]     time_ms,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 status_byte,
  output logic [6:0]                 data_addr,
  output logic [6:0]                 data_value,
  output logic                       last
);

  cmd_t    cmd;
  status_t st;

  rlft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .led_known (led_known),
    .st        (st),
    .cmd       (cmd)
  );

  rlft_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                       (clk),
    .rst                       (rst),
    .cmd                       (cmd),
    .st                        (st),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_data                  (cfg_data),
    .led_addr                  (led_addr),
    .channel                   (channel),
    .is_cc                     (is_cc),
    .range_channel_significant (range_channel_significant),
    .colour_value              (colour_value),
    .time_ms                   (time_ms),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .status_byte               (status_byte),
    .data_addr                 (data_addr),
    .data_value                (data_value),
    .last                      (last)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/rlft_ctrl.sv =====
// Sequencer for set searches, pump refill and the table walk.
`default_nettype none
module rlft_ctrl
  import rlft_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic    operation,
  input  wire logic    led_known,
  input  wire status_t st,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SET_SCAN,
    PUMP_MUL,
    PUMP_ADD,
    WALK,
    FLUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        cmd.capture    = accept;
        cmd.scan_start = accept;
        if (accept) begin
          if (operation) state_next = PUMP_MUL;
          else if (led_known) state_next = SET_SCAN;
        end
      end
      SET_SCAN: begin
        cmd.adv = 1'b1;
        if (st.q_match) begin
          cmd.set_upd = 1'b1;
          state_next  = IDLE;
        end else if (st.scan_done) begin
          cmd.set_app = !st.table_full;
          state_next  = IDLE;
        end
      end
      PUMP_MUL: begin
        cmd.pump_mul = 1'b1;
        state_next   = PUMP_ADD;
      end
      PUMP_ADD: begin
        cmd.pump_add   = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = WALK;
      end
      WALK: begin
        cmd.walk = 1'b1;
        // hold the walk while a new message has nowhere to go
        cmd.adv  = !(st.q_emit && st.pend_valid && !st.out_free);
        if (st.scan_done) state_next = FLUSH;
      end
      FLUSH: begin
        cmd.flush = 1'b1;
        if (!st.pend_valid || st.out_free) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rlft_dp.sv =====
// Datapath: entry memory, scan pipeline, token bucket and output staging.
`default_nettype none
module rlft_dp
  import rlft_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output status_t                    st,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [6:0]            led_addr,
  input  wire logic [4:0]            channel,
  input  wire logic                  is_cc,
  input  wire logic                  range_channel_significant,
  input  wire logic [6:0]            colour_value,
  input  wire logic [TIME_W-1:0]     time_ms,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 status_byte,
  output logic [6:0]                 data_addr,
  output logic [6:0]                 data_value,
  output logic                       last
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  entry_t mem [TABLE_ENTRIES];

  logic [RATE_W-1:0]       max_rate;
  logic [DCHAN_W-1:0]      default_chan;

  logic [6:0]              addr_r;
  logic [4:0]              chan_r;
  logic                    cc_r;
  logic                    rcs_r;
  logic [6:0]              val_r;
  logic [TIME_W-1:0]       time_r;

  logic [CW-1:0]           entry_count;
  logic [TOKEN_W-1:0]      token_level;
  logic [TIME_W-1:0]       last_pump_time;
  logic                    pumped_before;

  logic [PROD_W-1:0]       prod;
  logic [TOKEN_W-1:0]      cap;
  logic                    refill;
  logic [SUM_W-1:0]        sum;

  logic [CW-1:0]           rd_ptr;
  logic                    q_vld;
  logic [IW-1:0]           q_idx;
  entry_t                  q;
  logic [RESULT_CNT_W-1:0] n_sent;

  logic                    pend_valid;
  msg_t                    pend_msg;
  msg_t                    out_msg;

  logic                    issue;
  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  entry_t                  mem_wdata;
  entry_t                  upd_entry;
  entry_t                  app_entry;
  entry_t                  sent_entry;
  logic [4:0]              send_chan;
  logic [3:0]              nib;
  logic [DCHAN_W-1:0]      dchan_m1;
  msg_t                    new_msg;
  logic                    emit;
  logic                    out_free;
  logic                    load_walk;
  logic                    load_flush;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_rate     <= MAX_RATE_RESET;
      default_chan <= DCHAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_RATE:     max_rate     <= cfg_data[RATE_W-1:0];
        REG_DEFAULT_CHAN: default_chan <= cfg_data[DCHAN_W-1:0];
        default:          ;
      endcase
    end
  end

  // capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r <= led_addr;
      chan_r <= channel;
      cc_r   <= is_cc;
      rcs_r  <= range_channel_significant;
      val_r  <= colour_value;
      time_r <= time_ms;
    end
  end

  assign send_chan = (rcs_r && (chan_r != CHAN_AGNOSTIC)) ? chan_r : CHAN_AGNOSTIC;

  always_comb begin
    upd_entry            = q;
    upd_entry.cc         = cc_r;
    upd_entry.send_chan  = send_chan;
    upd_entry.want_valid = 1'b1;
    upd_entry.want_val   = val_r;

    app_entry            = '0;
    app_entry.addr       = addr_r;
    app_entry.key_chan   = chan_r;
    app_entry.cc         = cc_r;
    app_entry.send_chan  = send_chan;
    app_entry.want_valid = 1'b1;
    app_entry.want_val   = val_r;

    sent_entry            = q;
    sent_entry.sent_valid = 1'b1;
    sent_entry.sent_val   = q.want_val;
  end

  // message built from the entry under evaluation
  assign dchan_m1 = default_chan - DCHAN_W'(1);
  always_comb begin
    if (q.send_chan != CHAN_AGNOSTIC) nib = q.send_chan[3:0];
    else if (default_chan == '0) nib = 4'd0;
    else nib = dchan_m1[3:0];
    new_msg.status = (q.cc ? STATUS_CC : STATUS_NOTE) | {4'd0, nib & NIBBLE_MASK};
    new_msg.addr   = q.addr;
    new_msg.value  = q.want_val;
  end

  assign st.q_emit = q_vld && q.want_valid
                     && !(q.sent_valid && (q.want_val == q.sent_val))
                     && (token_level >= MILLI_PER_MSG)
                     && (n_sent < RESULT_CNT_W'(MAX_RESULTS));
  assign st.q_match    = q_vld && (q.addr == addr_r) && (q.key_chan == chan_r);
  assign st.scan_done  = (rd_ptr >= entry_count) && !q_vld;
  assign st.pend_valid = pend_valid;
  assign st.out_free   = out_free;
  assign st.table_full = (entry_count == CW'(TABLE_ENTRIES));

  assign issue      = cmd.adv && (rd_ptr < entry_count);
  assign emit       = cmd.walk && cmd.adv && st.q_emit;
  assign out_free   = !out_valid || out_ready;
  assign load_walk  = emit && pend_valid;
  assign load_flush = cmd.flush && pend_valid && out_free;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = q_idx;
    mem_wdata = sent_entry;
    if (cmd.set_upd) begin
      mem_we    = 1'b1;
      mem_wdata = upd_entry;
    end else if (cmd.set_app) begin
      mem_we    = 1'b1;
      mem_waddr = entry_count[IW-1:0];
      mem_wdata = app_entry;
    end else if (emit) begin
      mem_we = 1'b1;
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (issue) begin
      q     <= mem[rd_ptr[IW-1:0]];
      q_idx <= rd_ptr[IW-1:0];
    end
  end

  // scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      q_vld  <= 1'b0;
    end else if (cmd.scan_start) begin
      rd_ptr <= '0;
      q_vld  <= 1'b0;
    end else if (cmd.adv) begin
      q_vld <= issue;
      if (issue) rd_ptr <= rd_ptr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.set_app) begin
      entry_count <= entry_count + CW'(1);
    end
  end

  // token bucket: multiply, then add and saturate
  assign sum = SUM_W'(token_level) + SUM_W'(prod);

  always_ff @(posedge clk) begin
    if (cmd.pump_mul) begin
      prod   <= PROD_W'(time_r - last_pump_time) * PROD_W'(max_rate);
      cap    <= TOKEN_W'(max_rate) * MILLI_PER_MSG;
      refill <= time_r > last_pump_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_level    <= '0;
      last_pump_time <= '0;
      pumped_before  <= 1'b0;
      n_sent         <= '0;
    end else if (cmd.pump_add) begin
      if (!pumped_before) token_level <= cap;
      else if (refill) token_level <= (sum > SUM_W'(cap)) ? cap : sum[TOKEN_W-1:0];
      last_pump_time <= time_r;
      pumped_before  <= 1'b1;
      n_sent         <= '0;
    end else if (emit) begin
      token_level <= token_level - MILLI_PER_MSG;
      n_sent      <= n_sent + RESULT_CNT_W'(1);
    end
  end

  // one message held back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (emit) begin
      pend_valid <= 1'b1;
    end else if (load_flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) pend_msg <= new_msg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_walk || load_flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_walk || load_flush) begin
      out_msg <= pend_msg;
      last    <= load_flush;
    end
  end

  assign status_byte = out_msg.status;
  assign data_addr   = out_msg.addr;
  assign data_value  = out_msg.value;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the LED feedback table with token-bucket limiter.
`default_nettype none
module tb
  import rlft_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_PUMP = 1'b1;

  localparam int TABLE_DEPTH   = TABLE_ENTRIES_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_CYCLES  = 400;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef struct {
    logic        op;
    logic [6:0]  addr;
    logic [4:0]  chan;
    logic        known;
    logic        cc;
    logic        rcs;
    logic [6:0]  val;
    logic [31:0] t;
  } led_req_t;

  typedef struct {
    logic [7:0] status;
    logic [6:0] addr;
    logic [6:0] value;
    logic       last;
  } midi_msg_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  operation = 1'b0;
  logic [6:0]            led_addr = '0;
  logic [4:0]            channel = '0;
  logic                  led_known = 1'b0;
  logic                  is_cc = 1'b0;
  logic                  range_channel_significant = 1'b0;
  logic [6:0]            colour_value = '0;
  logic [TIME_W-1:0]     time_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            status_byte;
  logic [6:0]            data_addr;
  logic [6:0]            data_value;
  logic                  last;

  // Shadow of the block's state and registers
  entry_t            led_table [TABLE_DEPTH];
  int                led_count = 0;
  int unsigned       bucket = 0;
  logic [31:0]       last_pump_ms = '0;
  logic              pumped = 1'b0;
  logic [RATE_W-1:0] rate_reg = MAX_RATE_RESET;
  logic [4:0]        dchan_reg = DCHAN_RESET;

  midi_msg_t   pending_msgs [$];
  midi_msg_t   head_msg;
  logic [31:0] now_ms = '0;
  logic        idle_on = 1'b1;
  logic        stall_request = 1'b0;
  int          fail_count = 0;
  int          items_sent = 0;
  int          pumps_sent = 0;
  int          msgs_checked = 0;
  int          cfg_writes = 0;
  int          cycle_count = 0;

  rate_limited_led_feedback_table_unit dut (
    .clk                       (clk),
    .rst                       (rst),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_data                  (cfg_data),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .operation                 (operation),
    .led_addr                  (led_addr),
    .channel                   (channel),
    .led_known                 (led_known),
    .is_cc                     (is_cc),
    .range_channel_significant (range_channel_significant),
    .colour_value              (colour_value),
    .time_ms                   (time_ms),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .status_byte               (status_byte),
    .data_addr                 (data_addr),
    .data_value                (data_value),
    .last                      (last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random ready bursts, plus one long hold-off on request
  int ready_hold = 0;
  always @(posedge clk) begin
    if (stall_request) begin
      stall_request = 1'b0;
      ready_hold = STALL_CYCLES;
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      ready_hold = $urandom_range(1, 7) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_msgs.size() == 0) begin
        $error("unexpected message: status_byte %0h data_addr %0h data_value %0h",
               status_byte, data_addr, data_value);
        fail_count++;
      end else begin
        head_msg = pending_msgs.pop_front();
        msgs_checked++;
        if (status_byte !== head_msg.status) begin
          $error("status_byte expected %0h actual %0h", head_msg.status, status_byte);
          fail_count++;
        end
        if (data_addr !== head_msg.addr) begin
          $error("data_addr expected %0h actual %0h", head_msg.addr, data_addr);
          fail_count++;
        end
        if (data_value !== head_msg.value) begin
          $error("data_value expected %0h actual %0h", head_msg.value, data_value);
          fail_count++;
        end
        if (last !== head_msg.last) begin
          $error("last expected %0b actual %0b", head_msg.last, last);
          fail_count++;
        end
      end
    end
  end

  // Update the shadow table for one accepted item; queue the messages a pump sends
  task automatic predict_item(input led_req_t req);
    int          hit;
    int          n;
    int unsigned cap;
    longint unsigned lvl;
    logic [4:0]  dm1;
    logic [3:0]  nib;
    midi_msg_t   batch [MAX_RESULTS];
    hit = -1;
    n = 0;
    if (req.op == OP_SET) begin
      if (req.known) begin
        for (int i = 0; i < led_count; i++) begin
          if (hit < 0 && led_table[i].addr == req.addr && led_table[i].key_chan == req.chan)
            hit = i;
        end
        if (hit < 0 && led_count < TABLE_DEPTH) begin
          hit = led_count;
          led_table[hit] = '0;
          led_table[hit].addr = req.addr;
          led_table[hit].key_chan = req.chan;
          led_count++;
        end
        // drop the set when the table is full and the key is new
        if (hit >= 0) begin
          led_table[hit].cc = req.cc;
          led_table[hit].send_chan = (req.rcs && req.chan != CHAN_AGNOSTIC) ?
                                     req.chan : CHAN_AGNOSTIC;
          led_table[hit].want_valid = 1'b1;
          led_table[hit].want_val = req.val;
        end
      end
    end else begin
      pumps_sent++;
      cap = 32'(rate_reg) * 32'd1000;
      if (!pumped) begin
        bucket = cap;
      end else if (req.t > last_pump_ms) begin
        lvl = longint'(bucket) + longint'(req.t - last_pump_ms) * longint'(rate_reg);
        if (lvl > longint'(cap))
          lvl = longint'(cap);
        bucket = 32'(lvl);
      end
      last_pump_ms = req.t;
      pumped = 1'b1;
      dm1 = dchan_reg - 5'd1;
      for (int i = 0; i < led_count; i++) begin
        if (!led_table[i].want_valid)
          continue;
        if (led_table[i].sent_valid && led_table[i].want_val == led_table[i].sent_val)
          continue;
        if (bucket < 32'd1000)
          continue;
        if (n >= MAX_RESULTS)
          break;
        if (led_table[i].send_chan != CHAN_AGNOSTIC)
          nib = led_table[i].send_chan[3:0];
        else
          nib = (dchan_reg == 5'd0) ? 4'd0 : dm1[3:0];
        batch[n].status = (led_table[i].cc ? STATUS_CC : STATUS_NOTE) |
                          {4'h0, nib & NIBBLE_MASK};
        batch[n].addr = led_table[i].addr;
        batch[n].value = led_table[i].want_val;
        batch[n].last = 1'b0;
        n++;
        bucket -= 32'd1000;
        led_table[i].sent_val = led_table[i].want_val;
        led_table[i].sent_valid = 1'b1;
      end
      if (n > 0)
        batch[n-1].last = 1'b1;
      for (int i = 0; i < n; i++)
        pending_msgs.insert(pending_msgs.size(), batch[i]);
    end
  endtask

  task automatic send_item(input led_req_t req);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= req.op;
    led_addr <= req.addr;
    channel <= req.chan;
    led_known <= req.known;
    is_cc <= req.cc;
    range_channel_significant <= req.rcs;
    colour_value <= req.val;
    time_ms <= req.t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(req);
    items_sent++;
  endtask

  // Hold the input until every message is out and the last item has finished
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == REG_MAX_RATE)
      rate_reg = data[RATE_W-1:0];
    else
      dchan_reg = data[DCHAN_W-1:0];
    cfg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic led_req_t make_set(input logic [6:0] addr, input logic [4:0] chan,
                                        input logic known, input logic cc, input logic rcs,
                                        input logic [6:0] val);
    led_req_t req;
    req.op = OP_SET;
    req.addr = addr;
    req.chan = chan;
    req.known = known;
    req.cc = cc;
    req.rcs = rcs;
    req.val = val;
    req.t = $urandom;
    return req;
  endfunction

  function automatic led_req_t make_pump(input logic [31:0] t);
    led_req_t req;
    req.op = OP_PUMP;
    req.addr = 7'($urandom);
    req.chan = 5'($urandom);
    req.known = 1'($urandom);
    req.cc = 1'($urandom);
    req.rcs = 1'($urandom);
    req.val = 7'($urandom);
    req.t = t;
    return req;
  endfunction

  // Mostly updates of stored keys, some fresh keys, some unknown LEDs, pumps at varied times
  task automatic build_random_item(output led_req_t req);
    int k;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 9))
        0: ;
        1: now_ms = now_ms - 32'($urandom_range(1, 50));
        2: now_ms = $urandom;
        3: now_ms = now_ms + 32'($urandom_range(1000, 100000));
        default: now_ms = now_ms + 32'($urandom_range(1, 40));
      endcase
      req = make_pump(now_ms);
    end else begin
      req = make_set(7'($urandom), 5'($urandom), ($urandom_range(0, 9) != 0),
                     1'($urandom), 1'($urandom), 7'($urandom));
      if (led_count > 0 && $urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, led_count - 1);
        req.addr = led_table[k].addr;
        req.chan = led_table[k].key_chan;
      end else if ($urandom_range(0, 1) == 0) begin
        req.chan = CHAN_AGNOSTIC;
      end
    end
  endtask

  task automatic test_sets_and_first_pump();
    send_item(make_pump(32'd500));
    send_item(make_set(7'd127, 5'd31, 1'b0, 1'b1, 1'b1, 7'd127));
    send_item(make_set(7'd0, 5'd0, 1'b1, 1'b0, 1'b1, 7'd0));
    send_item(make_set(7'd127, CHAN_AGNOSTIC, 1'b1, 1'b1, 1'b1, 7'd127));
    send_item(make_set(7'd5, 5'd31, 1'b1, 1'b0, 1'b1, 7'd33));
    send_item(make_set(7'd6, 5'd3, 1'b1, 1'b1, 1'b0, 7'd1));
    send_item(make_pump(32'd500));
    send_item(make_pump(32'd400));
    // same value with a new type: nothing to resend
    send_item(make_set(7'd0, 5'd0, 1'b1, 1'b1, 1'b1, 7'd0));
    send_item(make_set(7'd5, 5'd31, 1'b1, 1'b0, 1'b1, 7'd34));
    send_item(make_pump(32'd600));
  endtask

  task automatic test_bucket_limits();
    wait_idle();
    write_reg(REG_MAX_RATE, 10'd1);
    write_reg(REG_DEFAULT_CHAN, {5'b10101, 5'd31});
    send_item(make_set(7'd127, CHAN_AGNOSTIC, 1'b1, 1'b0, 1'b1, 7'd3));
    send_item(make_set(7'd6, 5'd3, 1'b1, 1'b1, 1'b0, 7'd4));
    send_item(make_set(7'd5, 5'd31, 1'b1, 1'b1, 1'b1, 7'd5));
    // bucket is above the lowered capacity and still drains
    send_item(make_pump(32'd600));
    send_item(make_set(7'd0, 5'd0, 1'b1, 1'b0, 1'b1, 7'd9));
    send_item(make_set(7'd6, 5'd3, 1'b1, 1'b0, 1'b1, 7'd10));
    send_item(make_pump(32'd601));
    send_item(make_pump(32'd601));
    wait_idle();
    write_reg(REG_MAX_RATE, 10'd0);
    write_reg(REG_DEFAULT_CHAN, CFG_DATA_W'(CHAN_AGNOSTIC));
    send_item(make_pump(32'd5000));
    wait_idle();
    write_reg(REG_MAX_RATE, 10'd1023);
    write_reg(REG_DEFAULT_CHAN, 10'd1);
    send_item(make_pump(32'd5001));
    now_ms = 32'd5001;
  endtask

  task automatic test_table_full();
    logic [4:0] tail_chan;
    for (int i = 0; i < TABLE_DEPTH - 4; i++)
      send_item(make_set(7'(32 + i), 5'($urandom), 1'b1, 1'($urandom), 1'($urandom),
                         7'($urandom)));
    tail_chan = led_table[TABLE_DEPTH-1].key_chan;
    send_item(make_set(7'd100, 5'($urandom), 1'b1, 1'b0, 1'b1, 7'd77));
    send_item(make_set(7'd101, CHAN_AGNOSTIC, 1'b1, 1'b1, 1'b0, 7'd78));
    send_item(make_set(7'(32 + TABLE_DEPTH - 5), tail_chan, 1'b1, 1'b1, 1'b1, 7'd99));
    now_ms = now_ms + 32'd5000;
    send_item(make_pump(now_ms));
  endtask

  task automatic test_output_stall();
    led_req_t req;
    wait_idle();
    stall_request = 1'b1;
    // keep offering work while the receiver holds off
    for (int i = 0; i < 24; i++) begin
      if (i % 4 == 3) begin
        now_ms = now_ms + 32'd3000;
        req = make_pump(now_ms);
      end else begin
        req = make_set(led_table[i].addr, led_table[i].key_chan, 1'b1, 1'($urandom),
                       1'($urandom), led_table[i].want_val + 7'd1);
      end
      send_item(req);
    end
  endtask

  task automatic test_random_traffic();
    led_req_t req;
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0: begin write_reg(REG_MAX_RATE, 10'd100);  write_reg(REG_DEFAULT_CHAN, 10'd0);  end
        1: begin write_reg(REG_MAX_RATE, 10'd1);    write_reg(REG_DEFAULT_CHAN, 10'd31); end
        2: begin write_reg(REG_MAX_RATE, 10'd1023); write_reg(REG_DEFAULT_CHAN, 10'd17); end
        3: begin write_reg(REG_MAX_RATE, 10'd0);    write_reg(REG_DEFAULT_CHAN, 10'd16); end
        4: begin
          write_reg(REG_MAX_RATE, 10'($urandom_range(1, 1000)));
          write_reg(REG_DEFAULT_CHAN, 10'($urandom_range(0, 31)));
        end
        default: begin
          write_reg(REG_MAX_RATE, 10'd1000);
          write_reg(REG_DEFAULT_CHAN, 10'd1);
        end
      endcase
      idle_on = (p != 5);
      repeat (55) begin
        build_random_item(req);
        send_item(req);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_sets_and_first_pump();
    test_bucket_limits();
    test_table_full();
    test_output_stall();
    test_random_traffic();
    wait_idle();
    $display("covered %0d items (%0d pumps), %0d messages checked, %0d register writes",
             items_sent, pumps_sent, msgs_checked, cfg_writes);
    $display("table held %0d entries; rates 0 to 1023 and default channels 0 to 31 used",
             led_count);
    if (fail_count == 0 && pending_msgs.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/rlft_pkg.sv
hw/rtl/rlft_ctrl.sv
hw/rtl/rlft_dp.sv
hw/rtl/rate_limited_led_feedback_table_unit.sv
tb/tb.sv
